// File: hdl/active_expired_slice_scheduler_assert.svh
// Assertion macros for the scheduler RTL.
`ifndef ACTIVE_EXPIRED_SLICE_SCHEDULER_ASSERT_SVH
`define ACTIVE_EXPIRED_SLICE_SCHEDULER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define AESS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define AESS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: hdl/aess_pkg.sv
// Types and constants of the active/expired slice scheduler.
`default_nettype none
package aess_pkg;

  localparam int TASK_W            = 4;
  localparam int SLICE_W           = 8;
  localparam int COUNT_W           = 5;
  localparam int DEFAULT_MAX_TASKS = 16;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;
  localparam logic [SLICE_W-1:0] SLICE_ONE   = 8'd1;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_ACTIVATE   = 2'd1,
    OP_DEACTIVATE = 2'd2,
    OP_SCHEDULE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] task_id;
  } req_word_t;

  typedef struct packed {
    logic [TASK_W-1:0]  running_task;
    logic               running_valid;
    logic               switched;
    logic               need_resched;
    logic               rejected;
    logic [COUNT_W-1:0] active_count;
  } rsp_word_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic               cmp;
    logic               push_a;
    logic               drop_a;
    logic               dec_a;
    logic               push_e;
    logic               swap;
    logic [TASK_W-1:0]  key;
    logic [SLICE_W-1:0] fill;
  } cell_cmd_t;

  // What one cell shows to its neighbors and to the controller.
  typedef struct packed {
    logic               a_valid;
    logic [TASK_W-1:0]  a_id;
    logic [SLICE_W-1:0] a_slice;
    logic               e_valid;
    logic [TASK_W-1:0]  e_id;
    logic               match_a;
    logic               match_e;
    logic               low;
  } cell_stat_t;

  // Left of the first cell everything counts as occupied, right of the last
  // cell everything is empty.
  localparam cell_stat_t STAT_LEFT  = '{a_valid: 1'b1, e_valid: 1'b1, default: '0};
  localparam cell_stat_t STAT_RIGHT = '{default: '0};

endpackage
`default_nettype wire

// File: hdl/aess_chan_if.sv
// Valid/ready channels for request and response words.
`default_nettype none
interface aess_req_if;
  logic                 valid;
  logic                 ready;
  aess_pkg::req_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aess_rsp_if;
  logic                 valid;
  logic                 ready;
  aess_pkg::rsp_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/aess_cell.sv
// One queue slot: an active entry with its slice count and an expired entry.
`default_nettype none
module aess_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  aess_pkg::cell_cmd_t  cmd,
  input  aess_pkg::cell_stat_t left,
  input  aess_pkg::cell_stat_t right,
  input  logic                 shift_in,
  output logic                 shift_out,
  output aess_pkg::cell_stat_t stat
);

  logic                         a_valid;
  logic [aess_pkg::TASK_W-1:0]  a_id;
  logic [aess_pkg::SLICE_W-1:0] a_slice;
  logic                         e_valid;
  logic [aess_pkg::TASK_W-1:0]  e_id;
  logic                         match_a;
  logic                         match_e;
  logic                         low;
  logic                         shift;

  // The removal point and every slot behind it pull from the right neighbor.
  assign shift     = shift_in | match_a;
  assign shift_out = shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      e_valid <= 1'b0;
      match_a <= 1'b0;
      match_e <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        match_a <= a_valid && (a_id == cmd.key);
        match_e <= e_valid && (e_id == cmd.key);
        low     <= (a_slice <= aess_pkg::SLICE_ONE);
      end
      if (cmd.swap) begin
        a_id    <= e_id;
        a_slice <= cmd.fill;
        a_valid <= e_valid;
        e_valid <= 1'b0;
      end else begin
        if (cmd.push_a && !a_valid && left.a_valid) begin
          a_id    <= cmd.key;
          a_slice <= cmd.fill;
          a_valid <= 1'b1;
        end
        if (cmd.drop_a && shift) begin
          a_id    <= right.a_id;
          a_slice <= right.a_slice;
          a_valid <= right.a_valid;
        end
        if (cmd.dec_a && match_a) begin
          a_slice <= a_slice - aess_pkg::SLICE_ONE;
        end
        if (cmd.push_e && !e_valid && left.e_valid) begin
          e_id    <= cmd.key;
          e_valid <= 1'b1;
        end
      end
    end
  end

  assign stat = '{a_valid: a_valid, a_id: a_id, a_slice: a_slice,
                  e_valid: e_valid, e_id: e_id,
                  match_a: match_a, match_e: match_e, low: low};

endmodule
`default_nettype wire

// File: hdl/active_expired_slice_scheduler.sv
// Top level of the active/expired time-slice scheduler.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    op, task_id
//   rsp      out  valid / ready    running_task, running_valid, switched,
//                                  need_resched, rejected, active_count
//   cfg      in   cfg_we           cfg_data (slice_length)
//
// Each event goes through accept, a compare cycle in which every cell
// matches its entries against the key, and an update cycle in which the cells
// shift, push, decrement or swap and the response word is loaded.
// The next event is accepted in the cycle after the update, while the
// response may still wait in the output register; a stalled response holds
// the update cycle. Reset is synchronous and empties both queues at once
// through the cells' valid bits, so no clearing pass is needed.
`default_nettype none
`include "active_expired_slice_scheduler_assert.svh"
module active_expired_slice_scheduler #(
  parameter int MAX_TASKS = aess_pkg::DEFAULT_MAX_TASKS
) (
  input  logic                         clk,
  input  logic                         rst,
  aess_req_if.sink                     req,
  aess_rsp_if.source                   rsp,
  input  logic                         cfg_we,
  input  logic [aess_pkg::SLICE_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_TASKS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t                       state;
  aess_pkg::op_t                op_q;
  logic [aess_pkg::TASK_W-1:0]  key_q;
  logic [aess_pkg::SLICE_W-1:0] slice_length;
  logic [LEN_W-1:0]             active_len;
  logic [LEN_W-1:0]             expired_len;
  logic [aess_pkg::TASK_W-1:0]  current_task;
  logic                         current_valid;
  logic                         resched_flag;
  logic                         rsp_valid;
  aess_pkg::rsp_word_t          rsp_word;

  logic [LEN_W-1:0]             active_len_next;
  logic [LEN_W-1:0]             expired_len_next;
  logic [aess_pkg::TASK_W-1:0]  current_task_next;
  logic                         current_valid_next;
  logic                         resched_flag_next;
  logic                         switched;
  logic                         rejected;
  logic [aess_pkg::TASK_W-1:0]  head;
  logic                         want_push_a;
  logic                         want_drop_a;
  logic                         want_dec_a;
  logic                         want_push_e;
  logic                         want_swap;
  logic                         fire;
  logic                         accept;

  aess_pkg::cell_cmd_t          cmd;
  aess_pkg::cell_stat_t         st [MAX_TASKS+2];
  logic [MAX_TASKS-1:0]         shift_c;
  logic [MAX_TASKS-1:0]         m_a;
  logic [MAX_TASKS-1:0]         m_e;
  logic [MAX_TASKS-1:0]         m_low;
  logic [MAX_TASKS-1:0]         occ_a;
  logic                         a_hit;
  logic                         e_hit;
  logic                         low_hit;

  // The row of cells. Slot zero is the head of both queues; st[i+1] is cell
  // i, with fixed boundary words on either end of the row.
  assign st[0]           = aess_pkg::STAT_LEFT;
  assign st[MAX_TASKS+1] = aess_pkg::STAT_RIGHT;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic shift_in;
    if (i == 0) begin : g_first
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign shift_in = shift_c[i-1];
    end
    aess_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .left     (st[i]),
      .right    (st[i+2]),
      .shift_in (shift_in),
      .shift_out(shift_c[i]),
      .stat     (st[i+1])
    );
    assign m_a[i]   = st[i+1].match_a;
    assign m_e[i]   = st[i+1].match_e;
    assign m_low[i] = st[i+1].match_a & st[i+1].low;
    assign occ_a[i] = st[i+1].a_valid;
  end

  assign a_hit   = |m_a;
  assign e_hit   = |m_e;
  assign low_hit = |m_low;

  assign accept      = req.valid && req.ready;
  assign req.ready   = (state == ST_IDLE);
  assign fire        = (state == ST_UPD) && (!rsp_valid || rsp.ready);
  assign rsp.valid   = rsp_valid;
  assign rsp.data    = rsp_word;

  // Head of the queue that runs next: after a swap the expired head leads.
  assign head = (active_len == '0) ? st[1].e_id : st[1].a_id;

  // Decide the event from the match flags latched in the compare cycle.
  always_comb begin
    active_len_next    = active_len;
    expired_len_next   = expired_len;
    current_task_next  = current_task;
    current_valid_next = current_valid;
    resched_flag_next  = resched_flag;
    switched           = 1'b0;
    rejected           = 1'b0;
    want_push_a        = 1'b0;
    want_drop_a        = 1'b0;
    want_dec_a         = 1'b0;
    want_push_e        = 1'b0;
    want_swap          = 1'b0;
    unique case (op_q)
      aess_pkg::OP_TICK: begin
        // Only a running task still in the active queue uses up a slice.
        if (current_valid && a_hit) begin
          if (low_hit) begin
            want_drop_a       = 1'b1;
            want_push_e       = 1'b1;
            active_len_next   = active_len - LEN_W'(1);
            expired_len_next  = expired_len + LEN_W'(1);
            resched_flag_next = 1'b1;
          end else begin
            want_dec_a = 1'b1;
          end
        end
      end
      aess_pkg::OP_ACTIVATE: begin
        if ((int'(key_q) >= MAX_TASKS) || a_hit || e_hit) begin
          rejected = 1'b1;
        end else begin
          want_push_a     = 1'b1;
          active_len_next = active_len + LEN_W'(1);
        end
      end
      aess_pkg::OP_DEACTIVATE: begin
        // A task beyond the table can never be queued, so it never matches.
        if (!a_hit) begin
          rejected = 1'b1;
        end else begin
          want_drop_a     = 1'b1;
          active_len_next = active_len - LEN_W'(1);
        end
      end
      aess_pkg::OP_SCHEDULE: begin
        resched_flag_next = 1'b0;
        if (active_len == '0 && expired_len != '0) begin
          want_swap        = 1'b1;
          active_len_next  = expired_len;
          expired_len_next = '0;
        end
        if (active_len == '0 && expired_len == '0) begin
          current_valid_next = 1'b0;
          current_task_next  = '0;
        end else begin
          switched           = !current_valid || (head != current_task);
          current_task_next  = head;
          current_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.key    = key_q;
    cmd.fill   = slice_length;
    cmd.cmp    = (state == ST_CMP);
    cmd.push_a = fire && want_push_a;
    cmd.drop_a = fire && want_drop_a;
    cmd.dec_a  = fire && want_dec_a;
    cmd.push_e = fire && want_push_e;
    cmd.swap   = fire && want_swap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slice_length  <= aess_pkg::SLICE_RESET;
      active_len    <= '0;
      expired_len   <= '0;
      current_task  <= '0;
      current_valid <= 1'b0;
      resched_flag  <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        slice_length <= cfg_data;
      end
      // A word taken in the same cycle as an update is replaced by the new one.
      if (rsp_valid && rsp.ready && !fire) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q  <= req.data.op;
            // A tick looks for the running task, the others for the named one.
            key_q <= (req.data.op == aess_pkg::OP_TICK) ? current_task
                                                        : req.data.task_id;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (fire) begin
            active_len             <= active_len_next;
            expired_len            <= expired_len_next;
            current_task           <= current_task_next;
            current_valid          <= current_valid_next;
            resched_flag           <= resched_flag_next;
            rsp_valid              <= 1'b1;
            rsp_word.running_task  <= current_task_next;
            rsp_word.running_valid <= current_valid_next;
            rsp_word.switched      <= switched;
            rsp_word.need_resched  <= resched_flag_next;
            rsp_word.rejected      <= rejected;
            rsp_word.active_count  <= aess_pkg::COUNT_W'(active_len_next);
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Queue contents are unique, so at most one slot matches a key.
  `AESS_ASSERT_ALWAYS(a_unique_match, state != ST_UPD || ($onehot0(m_a) && $onehot0(m_e)), "duplicate task in a queue")
  // The length counter tracks the occupied active slots.
  `AESS_ASSERT_ALWAYS(a_len_track, $countones(occ_a) == int'(active_len), "active length out of step with cells")
  // A task is never in both queues at once.
  `AESS_ASSERT_ALWAYS(a_both_queues, state != ST_UPD || !(a_hit && e_hit), "task found in both queues")
  // An update always leaves a response word waiting.
  `AESS_ASSERT_NEXT(a_fire_rsp, fire, rsp_valid && state == ST_IDLE, "update without response")
  // With no task running the reported task reads zero.
  `AESS_ASSERT_ALWAYS(a_idle_task, !rsp_valid || rsp_word.running_valid || rsp_word.running_task == '0, "idle response names a task")

endmodule
`default_nettype wire

// File: bench/tb_active_expired_slice_scheduler.sv
// Self-checking testbench for the active/expired time-slice scheduler.
`timescale 1ns / 1ps
module tb_active_expired_slice_scheduler;

  // The watchdog limit is the number of cycles without any handshake. The
  // slowest correct word sees a long sender gap, a long receiver stall and
  // the block's own accept, compare and update steps, so this limit leaves
  // a wide margin over what such a word needs.
  localparam int IDLE_LIMIT   = 4000;
  // Cycles allowed after the last expected word before a register write or
  // the end of the run.
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 7;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [aess_pkg::SLICE_W-1:0]   cfg_data;

  aess_req_if req_ch ();
  aess_rsp_if rsp_ch ();

  active_expired_slice_scheduler dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Request words waiting to be sent, and response words that the scheduler
  // still owes us, oldest first.
  aess_pkg::req_word_t pending_events[$];
  aess_pkg::rsp_word_t expected_words[$];

  // Our own copy of the scheduler state. It starts in the reset state and is
  // only advanced when the block accepts a request word.
  logic [aess_pkg::TASK_W-1:0]  run_q[$];
  logic [aess_pkg::TASK_W-1:0]  exp_tasks[$];
  logic [aess_pkg::SLICE_W-1:0] slices_left[aess_pkg::DEFAULT_MAX_TASKS] = '{default: '0};
  logic [aess_pkg::TASK_W-1:0]  cur_task     = '0;
  logic                         cur_valid    = 1'b0;
  logic                         resched      = 1'b0;
  logic [aess_pkg::SLICE_W-1:0] slice_len    = aess_pkg::SLICE_RESET;

  // When quiet is set neither side inserts gaps, so words flow back to back.
  logic quiet = 1'b0;

  int errors      = 0;
  int idle_cycles = 0;
  int req_gap     = 0;
  int rsp_stall   = 0;

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.data     = '0;
    rsp_ch.ready    = 1'b0;
    forever #4 clk = ~clk;
  end

  // Reset is held at the start of the run and then released for good.
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic aess_pkg::req_word_t make_event(aess_pkg::op_t o,
                                                     logic [aess_pkg::TASK_W-1:0] id);
    aess_pkg::req_word_t w;
    w.op      = o;
    w.task_id = id;
    return w;
  endfunction

  // Position of a task in a queue, or -1 when it is not there.
  function automatic int find_task(ref logic [aess_pkg::TASK_W-1:0] q[$],
                                   input logic [aess_pkg::TASK_W-1:0] id);
    foreach (q[i])
      if (q[i] == id)
        return i;
    return -1;
  endfunction

  // Applies one event to our copy of the scheduler and returns the response
  // word the block must produce for it.
  function automatic aess_pkg::rsp_word_t advance_scheduler(aess_pkg::req_word_t w);
    aess_pkg::rsp_word_t r;
    int                  pos;
    logic                sw;
    logic                rej;
    sw  = 1'b0;
    rej = 1'b0;
    case (w.op)
      aess_pkg::OP_TICK: begin
        // A tick only counts when the running task still sits in the active
        // queue; a runner that was deactivated or already expired is ignored.
        if (cur_valid) begin
          pos = find_task(run_q, cur_task);
          if (pos >= 0) begin
            if (slices_left[cur_task] <= aess_pkg::SLICE_ONE) begin
              // A count of zero or one both mean the slice is used up.
              slices_left[cur_task] = '0;
              run_q.delete(pos);
              exp_tasks.push_back(cur_task);
              resched = 1'b1;
            end else begin
              slices_left[cur_task] = slices_left[cur_task] - aess_pkg::SLICE_ONE;
            end
          end
        end
      end
      aess_pkg::OP_ACTIVATE: begin
        // A task that is queued anywhere, active or expired, is refused.
        if (find_task(run_q, w.task_id) >= 0 ||
            find_task(exp_tasks, w.task_id) >= 0) begin
          rej = 1'b1;
        end else begin
          slices_left[w.task_id] = slice_len;
          run_q.push_back(w.task_id);
        end
      end
      aess_pkg::OP_DEACTIVATE: begin
        // Only the active queue is searched; an expired task stays put. The
        // running task may leave the queue and still be reported as running.
        pos = find_task(run_q, w.task_id);
        if (pos < 0)
          rej = 1'b1;
        else
          run_q.delete(pos);
      end
      default: begin
        resched = 1'b0;
        if (run_q.size() == 0 && exp_tasks.size() > 0) begin
          // The expired queue becomes the active one and every task in it
          // gets a fresh slice.
          run_q = exp_tasks;
          exp_tasks.delete();
          foreach (run_q[i])
            slices_left[run_q[i]] = slice_len;
        end
        if (run_q.size() == 0) begin
          cur_valid = 1'b0;
          cur_task  = '0;
        end else begin
          sw        = !cur_valid || run_q[0] != cur_task;
          cur_task  = run_q[0];
          cur_valid = 1'b1;
        end
      end
    endcase
    r.running_task  = cur_valid ? cur_task : '0;
    r.running_valid = cur_valid;
    r.switched      = sw;
    r.need_resched  = resched;
    r.rejected      = rej;
    r.active_count  = aess_pkg::COUNT_W'(run_q.size());
    return r;
  endfunction

  // Gap length for either side: mostly none, often short, rarely long.
  function automatic int pick_gap();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random event. Task ids mostly come from a small pool so that activates
  // and deactivates hit queued tasks often; the rest span the whole field.
  function automatic aess_pkg::req_word_t random_event(int pool_hi);
    int                          r;
    aess_pkg::op_t               o;
    logic [aess_pkg::TASK_W-1:0] id;
    r = $urandom_range(0, 99);
    if (r < 40)
      o = aess_pkg::OP_TICK;
    else if (r < 60)
      o = aess_pkg::OP_ACTIVATE;
    else if (r < 73)
      o = aess_pkg::OP_DEACTIVATE;
    else
      o = aess_pkg::OP_SCHEDULE;
    if ($urandom_range(0, 9) == 0)
      id = aess_pkg::TASK_W'($urandom_range(0, 15));
    else
      id = aess_pkg::TASK_W'($urandom_range(0, pool_hi));
    return make_event(o, id);
  endfunction

  // Request driver. A word is offered when the previous one has gone and the
  // gap counter has run out; each accepted word is predicted right away.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        expected_words.push_back(advance_scheduler(req_ch.data));
      if (!req_ch.valid || req_ch.ready) begin
        if (req_gap > 0) begin
          req_gap = req_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          req_ch.data  <= pending_events.pop_front();
          req_ch.valid <= 1'b1;
          req_gap = pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors = errors + 1;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Response monitor. Each accepted word is checked against the oldest
  // expectation; ready is dropped for random stretches.
  always @(posedge clk) begin
    aess_pkg::rsp_word_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_words.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected word, expected none actual %h", $time, rsp_ch.data);
        end else begin
          want = expected_words.pop_front();
          check_field("running_task", want.running_task, rsp_ch.data.running_task);
          check_field("running_valid", want.running_valid, rsp_ch.data.running_valid);
          check_field("switched", want.switched, rsp_ch.data.switched);
          check_field("need_resched", want.need_resched, rsp_ch.data.need_resched);
          check_field("rejected", want.rejected, rsp_ch.data.rejected);
          check_field("active_count", want.active_count, rsp_ch.data.active_count);
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall = rsp_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        rsp_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Waits until every queued word has been sent and answered, then gives the
  // block its settle time. Sampling on the falling edge keeps this clear of
  // the updates made at the rising edge.
  task automatic drain();
    do
      @(negedge clk);
    while (pending_events.size() > 0 || req_ch.valid || expected_words.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write while the block is idle. The value takes effect at the
  // edge where the write enable is seen high.
  task automatic write_slice_length(logic [aess_pkg::SLICE_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    slice_len = value;
    @(negedge clk);
  endtask

  initial begin
    logic [aess_pkg::SLICE_W-1:0] phase_len[NUM_PHASES];
    int                           phase_items[NUM_PHASES];
    int                           phase_pool[NUM_PHASES];
    phase_len   = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3, 8'd9, 8'd5};
    phase_items = '{100, 320, 160, 320, 300, 260, 220};
    phase_pool  = '{3, 15, 3, 7, 15, 5, 3};
    phase_len[5] = aess_pkg::SLICE_W'($urandom_range(4, 20));

    while (rst)
      @(negedge clk);

    // Directed part at the reset slice length of five.
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd0));    // nothing runnable
    pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd0));        // tick with no runner
    pending_events.push_back(make_event(aess_pkg::OP_ACTIVATE, 4'd0));
    pending_events.push_back(make_event(aess_pkg::OP_ACTIVATE, 4'd15));
    pending_events.push_back(make_event(aess_pkg::OP_ACTIVATE, 4'd0));    // already queued
    pending_events.push_back(make_event(aess_pkg::OP_DEACTIVATE, 4'd7));  // absent task
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd9));    // switch to task 0
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd6));    // same task again
    repeat (5)
      pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd10));     // last one expires it
    pending_events.push_back(make_event(aess_pkg::OP_ACTIVATE, 4'd0));    // queued as expired
    pending_events.push_back(make_event(aess_pkg::OP_DEACTIVATE, 4'd0));  // expired stays
    pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd5));        // runner not active
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd0));    // runs task 15
    pending_events.push_back(make_event(aess_pkg::OP_DEACTIVATE, 4'd15)); // running task leaves
    pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd0));        // ignored
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd0));    // queues swap
    pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd0));
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd0));
    pending_events.push_back(make_event(aess_pkg::OP_DEACTIVATE, 4'd0));
    pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd0));    // both queues empty
    drain();

    // Random phases, each at its own slice length. The first one opens with
    // a zero slice length, where a task expires on its first tick, even right
    // after a refill.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_slice_length(phase_len[p]);
      quiet = (p == 3);
      if (p == 0) begin
        pending_events.push_back(make_event(aess_pkg::OP_ACTIVATE, 4'd3));
        pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd3));
        pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd3));
        pending_events.push_back(make_event(aess_pkg::OP_SCHEDULE, 4'd3));
        pending_events.push_back(make_event(aess_pkg::OP_TICK, 4'd3));
      end
      for (int n = 0; n < phase_items[p]; n++)
        pending_events.push_back(random_event(phase_pool[p]));
      drain();
    end

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
